>>> design/bsc_pkg.sv
// Shared types and constants of the breath sensor conditioner.
package bsc_pkg;

  // Register map: index i sits at byte address 4*i.
  localparam int REG_IDX_BITS  = 3;
  localparam int CFG_ADDR_BITS = REG_IDX_BITS + 2;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_WARMUP       = 3'd0,
    REG_THR_OFFSET   = 3'd1,
    REG_HOLD         = 3'd2,
    REG_STUCK_WINDOW = 3'd3,
    REG_STUCK_SPREAD = 3'd4,
    REG_STUCK_LOW    = 3'd5,
    REG_STUCK_HIGH   = 3'd6
  } reg_idx_t;

  // Register reset values.
  localparam logic [15:0] WARMUP_RESET      = 16'd1000;
  localparam logic [11:0] THR_OFFSET_RESET  = 12'd100;
  localparam logic [7:0]  HOLD_RESET        = 8'd100;
  localparam logic [15:0] STUCK_WIN_RESET   = 16'd20000;
  localparam logic [11:0] STUCK_SPR_RESET   = 12'd50;
  localparam logic [11:0] STUCK_LOW_RESET   = 12'd20;
  localparam logic [11:0] STUCK_HIGH_RESET  = 12'd800;

  // Calibration constants.
  localparam int THR_MIN_BITS = 12;
  localparam int CLAMP_POS    = 4000;
  localparam int CLAMP_NEG    = 100;
  localparam int ZERO_RESET   = 1900;
  localparam int POS_RESET    = 2000;
  localparam int NEG_RESET    = 1800;

  // Gain = 7 * 2^F / (5 * divisor), i.e. 1.4 / divisor.
  localparam int GAIN_NUM    = 7;
  localparam int GAIN_BITS   = 32;
  localparam int LEVEL_BITS  = 16;
  localparam int LEVEL_MAX   = 32767;
  localparam int STUCK_BITS  = 17;

  typedef struct packed {
    logic [15:0] warmup_samples;
    logic [11:0] threshold_offset;
    logic [7:0]  hold_samples;
    logic [15:0] stuck_window;
    logic [11:0] stuck_spread;
    logic [11:0] stuck_low_dev;
    logic [11:0] stuck_high_dev;
  } bsc_cfg_t;

  typedef struct packed {
    logic                         stream_start;
    logic                         value_valid;
    logic signed [LEVEL_BITS-1:0] breath_value;
    logic                         stream_end;
    logic                         stuck_alarm;
  } bsc_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_ROUND,
    ST_DPOS_GO,
    ST_DPOS_WAIT,
    ST_DNEG_GO,
    ST_DNEG_WAIT
  } bsc_state_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic mul;
    logic load_out;
    logic div_start;
    logic div_sel_neg;
    logic load_pos_gain;
    logic load_neg_gain;
  } bsc_cmd_t;

  typedef struct packed {
    logic calibrated;
    logic calib_now;
    logic div_done;
    logic out_free;
  } bsc_stat_t;

endpackage

>>> design/bsc_stream_if.sv
// Valid/ready stream channel carrying one word of a given type.
interface bsc_stream_if #(parameter type data_t = logic);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/bsc_regs.sv
// APB-style configuration register file of the breath sensor conditioner.
module bsc_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bsc_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [bsc_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [bsc_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                               pready,
  output bsc_pkg::bsc_cfg_t                  cfg
);
  import bsc_pkg::*;

  bsc_cfg_t cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_WARMUP:       cfg_nxt.warmup_samples   = pwdata[15:0];
        REG_THR_OFFSET:   cfg_nxt.threshold_offset = pwdata[11:0];
        REG_HOLD:         cfg_nxt.hold_samples     = pwdata[7:0];
        REG_STUCK_WINDOW: cfg_nxt.stuck_window     = pwdata[15:0];
        REG_STUCK_SPREAD: cfg_nxt.stuck_spread     = pwdata[11:0];
        REG_STUCK_LOW:    cfg_nxt.stuck_low_dev    = pwdata[11:0];
        REG_STUCK_HIGH:   cfg_nxt.stuck_high_dev   = pwdata[11:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WARMUP:       prdata = CFG_DATA_BITS'(cfg_r.warmup_samples);
      REG_THR_OFFSET:   prdata = CFG_DATA_BITS'(cfg_r.threshold_offset);
      REG_HOLD:         prdata = CFG_DATA_BITS'(cfg_r.hold_samples);
      REG_STUCK_WINDOW: prdata = CFG_DATA_BITS'(cfg_r.stuck_window);
      REG_STUCK_SPREAD: prdata = CFG_DATA_BITS'(cfg_r.stuck_spread);
      REG_STUCK_LOW:    prdata = CFG_DATA_BITS'(cfg_r.stuck_low_dev);
      REG_STUCK_HIGH:   prdata = CFG_DATA_BITS'(cfg_r.stuck_high_dev);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.warmup_samples   <= WARMUP_RESET;
      cfg_r.threshold_offset <= THR_OFFSET_RESET;
      cfg_r.hold_samples     <= HOLD_RESET;
      cfg_r.stuck_window     <= STUCK_WIN_RESET;
      cfg_r.stuck_spread     <= STUCK_SPR_RESET;
      cfg_r.stuck_low_dev    <= STUCK_LOW_RESET;
      cfg_r.stuck_high_dev   <= STUCK_HIGH_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> design/bsc_div.sv
// Restoring serial divider, one quotient bit per cycle.
module bsc_div #(
  parameter int NUM_BITS = 31,
  parameter int DEN_BITS = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                done,
  output logic [NUM_BITS-1:0] quot
);
  localparam int CW = $clog2(NUM_BITS);

  logic [DEN_BITS-1:0] rem_r, rem_nxt, den_r;
  logic [NUM_BITS-1:0] quo_r, quo_nxt;
  logic [CW-1:0]       cnt_r;
  logic                busy_r, done_r;
  logic [DEN_BITS:0]   rem_sh, rem_dif;
  logic                ge, last;

  assign rem_sh  = {rem_r, quo_r[NUM_BITS-1]};
  assign rem_dif = rem_sh - {1'b0, den_r};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_nxt = ge ? rem_dif[DEN_BITS-1:0] : rem_sh[DEN_BITS-1:0];
  assign quo_nxt = {quo_r[NUM_BITS-2:0], ge};
  assign last    = cnt_r == CW'(NUM_BITS - 1);

  assign done = done_r;
  assign quot = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

endmodule

>>> design/bsc_ctrl.sv
// Sequencing state machine of the breath sensor conditioner.
module bsc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bsc_pkg::bsc_stat_t stat,
  output bsc_pkg::bsc_cmd_t  cmd
);
  import bsc_pkg::*;

  bsc_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (stat.calibrated) state_nxt = ST_MUL;
        else if (stat.calib_now) state_nxt = ST_DPOS_GO;
        else state_nxt = ST_IDLE;
      end
      ST_MUL:       state_nxt = ST_ROUND;
      ST_ROUND: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      ST_DPOS_GO:   state_nxt = ST_DPOS_WAIT;
      ST_DPOS_WAIT: begin
        if (stat.div_done) state_nxt = ST_DNEG_GO;
      end
      ST_DNEG_GO:   state_nxt = ST_DNEG_WAIT;
      ST_DNEG_WAIT: begin
        if (stat.div_done) state_nxt = ST_IDLE;
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EVAL:  cmd.eval = 1'b1;
      ST_MUL:   cmd.mul  = 1'b1;
      ST_ROUND: cmd.load_out = stat.out_free;
      ST_DPOS_GO: begin
        cmd.div_start   = 1'b1;
        cmd.div_sel_neg = 1'b0;
      end
      ST_DPOS_WAIT: cmd.load_pos_gain = stat.div_done;
      ST_DNEG_GO: begin
        cmd.div_start   = 1'b1;
        cmd.div_sel_neg = 1'b1;
      end
      ST_DNEG_WAIT: cmd.load_neg_gain = stat.div_done;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A divider result may only land while a gain is being waited for.
  a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> (state_r == ST_DPOS_WAIT || state_r == ST_DNEG_WAIT))
    else $error("divider finished outside a gain wait state");

endmodule

>>> design/bsc_dp.sv
// Datapath: warm-up, calibration, hold, stuck detection, level and output word.
module bsc_dp #(
  parameter int SAMPLE_BITS    = 12,
  parameter int GAIN_FRAC_BITS = 27
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  bsc_pkg::bsc_cfg_t      cfg,
  input  bsc_pkg::bsc_cmd_t      cmd,
  output bsc_pkg::bsc_stat_t     stat,
  input  logic                   out_ready,
  output logic                   out_valid,
  output bsc_pkg::bsc_result_t   out_data
);
  import bsc_pkg::*;

  localparam int TW  = (SAMPLE_BITS > THR_MIN_BITS) ? SAMPLE_BITS : THR_MIN_BITS;
  localparam int TW1 = TW + 1;
  localparam int SH  = GAIN_FRAC_BITS - 15;
  localparam int PW  = TW + GAIN_BITS;
  localparam int NW  = GAIN_FRAC_BITS + 4;
  localparam int DW  = TW + 3;
  localparam logic [TW-1:0]          FULL_SCALE = TW'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
  localparam logic [PW:0]            RND_HALF   = (PW+1)'(1) << (SH - 1);

  // Model state
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [15:0]            warm_cnt_r, warm_cnt_nxt;
  logic                   calibrated_r;
  logic [TW-1:0]          zero_r, pos_thr_r, neg_thr_r;
  logic [GAIN_BITS-1:0]   pos_gain_r, neg_gain_r;
  logic [7:0]             hold_r, hold_nxt;
  logic [STUCK_BITS-1:0]  stk_cnt_r, stk_cnt_nxt;
  logic [SAMPLE_BITS-1:0] stk_min_r, stk_min_nxt, stk_max_r, stk_max_nxt;

  // Per-item pipeline
  logic [TW-1:0]          mag_r, mag_nxt;
  logic [GAIN_BITS-1:0]   gain_r, gain_nxt;
  logic                   neg_r, lvl_en_r, lvl_en_nxt;
  logic                   start_r, start_nxt, valid_r, valid_nxt;
  logic                   end_r, end_nxt, alarm_r, alarm_nxt;
  logic [PW-1:0]          prod_r;
  logic                   out_valid_r;
  bsc_result_t            out_data_r;

  // Warm-up and calibration
  logic [TW-1:0]  samp;
  logic [15:0]    warm_eff;
  logic           calib_now;
  logic [TW1-1:0] pos_sum, neg_floor;
  logic [TW-1:0]  pos_cal, neg_cal;

  assign samp         = TW'(sample_r);
  assign warm_cnt_nxt = (warm_cnt_r == 16'hFFFF) ? warm_cnt_r : warm_cnt_r + 16'd1;
  assign warm_eff     = (cfg.warmup_samples == 16'd0) ? 16'd1 : cfg.warmup_samples;
  assign calib_now    = !calibrated_r && (warm_cnt_nxt >= warm_eff);
  assign pos_sum      = TW1'(samp) + TW1'(cfg.threshold_offset);
  assign pos_cal      = (pos_sum > TW1'(CLAMP_POS)) ? TW'(CLAMP_POS) : pos_sum[TW-1:0];
  assign neg_floor    = TW1'(cfg.threshold_offset) + TW1'(CLAMP_NEG);
  assign neg_cal      = (TW1'(samp) >= neg_floor) ? samp - TW'(cfg.threshold_offset)
                                                  : TW'(CLAMP_NEG);

  // Stuck-pipe run
  logic [TW-1:0]          dev;
  logic                   in_band, window_hit;
  logic [SAMPLE_BITS-1:0] min_upd, max_upd, spread;
  logic [STUCK_BITS-1:0]  cnt_upd;

  assign dev        = (samp >= zero_r) ? samp - zero_r : zero_r - samp;
  assign in_band    = (dev > TW'(cfg.stuck_low_dev)) && (dev < TW'(cfg.stuck_high_dev));
  assign min_upd    = (sample_r < stk_min_r) ? sample_r : stk_min_r;
  assign max_upd    = (sample_r > stk_max_r) ? sample_r : stk_max_r;
  assign cnt_upd    = stk_cnt_r + STUCK_BITS'(1);
  assign window_hit = cnt_upd > STUCK_BITS'(cfg.stuck_window);
  assign spread     = (max_upd >= min_upd) ? max_upd - min_upd : '0;

  always_comb begin
    alarm_nxt = 1'b0;
    if (in_band && !window_hit) begin
      stk_cnt_nxt = cnt_upd;
      stk_min_nxt = min_upd;
      stk_max_nxt = max_upd;
    end else begin
      stk_cnt_nxt = '0;
      stk_min_nxt = SAMPLE_MAX;
      stk_max_nxt = '0;
      alarm_nxt   = in_band && (TW'(spread) < TW'(cfg.stuck_spread));
    end
  end

  // Hold countdown and level selection
  logic       over_pos, under_neg, over;
  logic [7:0] hold_load, hold_mid;

  assign over_pos  = samp > pos_thr_r;
  assign under_neg = samp < neg_thr_r;
  assign over      = over_pos || under_neg;
  assign hold_load = (cfg.hold_samples == 8'd0) ? 8'd1 : cfg.hold_samples;
  assign hold_mid  = over ? hold_load : hold_r;

  always_comb begin
    start_nxt  = over && (hold_r == 8'd0);
    valid_nxt  = hold_mid != 8'd0;
    hold_nxt   = valid_nxt ? hold_mid - 8'd1 : hold_mid;
    end_nxt    = valid_nxt && (hold_nxt == 8'd0);
    lvl_en_nxt = valid_nxt && (hold_nxt != 8'd0) && over;
    // negative branch wins when both thresholds are crossed
    mag_nxt    = under_neg ? neg_thr_r - samp : samp - pos_thr_r;
    gain_nxt   = under_neg ? neg_gain_r : pos_gain_r;
  end

  // Gain divider, shared by both gains
  logic [TW-1:0]   pos_div, divisor;
  logic [DW-1:0]   den;
  logic [NW-1:0]   num, quot;
  logic            div_done;

  assign pos_div = (FULL_SCALE > pos_thr_r) ? FULL_SCALE - pos_thr_r : TW'(1);
  assign divisor = cmd.div_sel_neg ? neg_thr_r : pos_div;
  assign den     = (DW'(divisor) << 2) + DW'(divisor);
  assign num     = (NW'(GAIN_NUM) << GAIN_FRAC_BITS) + NW'(den >> 1);

  bsc_div #(
    .NUM_BITS (NW),
    .DEN_BITS (DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

  // Rounding and saturation of the level
  logic [PW:0]                  rnd_sum, rnd_q;
  logic [LEVEL_BITS-1:0]        lvl_mag;
  logic signed [LEVEL_BITS-1:0] lvl_val;

  assign rnd_sum = {1'b0, prod_r} + RND_HALF;
  assign rnd_q   = rnd_sum >> SH;
  assign lvl_mag = (rnd_q > (PW+1)'(LEVEL_MAX)) ? LEVEL_BITS'(LEVEL_MAX)
                                                : rnd_q[LEVEL_BITS-1:0];
  assign lvl_val = !lvl_en_r ? '0 : (neg_r ? -$signed(lvl_mag) : $signed(lvl_mag));

  assign stat.calibrated = calibrated_r;
  assign stat.calib_now  = calib_now;
  assign stat.div_done   = div_done;
  assign stat.out_free   = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_cnt_r   <= '0;
      calibrated_r <= 1'b0;
      zero_r       <= TW'(ZERO_RESET);
      pos_thr_r    <= TW'(POS_RESET);
      neg_thr_r    <= TW'(NEG_RESET);
      pos_gain_r   <= '0;
      neg_gain_r   <= '0;
      hold_r       <= '0;
      stk_cnt_r    <= '0;
      stk_min_r    <= SAMPLE_MAX;
      stk_max_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.eval && !calibrated_r) begin
        warm_cnt_r <= warm_cnt_nxt;
        if (calib_now) begin
          calibrated_r <= 1'b1;
          zero_r       <= samp;
          pos_thr_r    <= pos_cal;
          neg_thr_r    <= neg_cal;
        end
      end
      if (cmd.eval && calibrated_r) begin
        hold_r    <= hold_nxt;
        stk_cnt_r <= stk_cnt_nxt;
        stk_min_r <= stk_min_nxt;
        stk_max_r <= stk_max_nxt;
      end
      if (cmd.load_pos_gain) pos_gain_r <= GAIN_BITS'(quot);
      if (cmd.load_neg_gain) neg_gain_r <= GAIN_BITS'(quot);
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) sample_r <= in_sample;
    if (cmd.eval) begin
      mag_r    <= mag_nxt;
      gain_r   <= gain_nxt;
      neg_r    <= under_neg;
      lvl_en_r <= lvl_en_nxt;
      start_r  <= start_nxt;
      valid_r  <= valid_nxt;
      end_r    <= end_nxt;
      alarm_r  <= alarm_nxt;
    end
    if (cmd.mul) prod_r <= PW'(mag_r) * PW'(gain_r);
    if (cmd.load_out) begin
      out_data_r.stream_start <= start_r;
      out_data_r.value_valid  <= valid_r;
      out_data_r.breath_value <= lvl_val;
      out_data_r.stream_end   <= end_r;
      out_data_r.stuck_alarm  <= alarm_r;
    end
  end

  a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("output word overwritten before it was taken");

  a_calib_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    calibrated_r |=> calibrated_r)
    else $error("calibration lost without reset");

  a_zero_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (!out_data_r.value_valid || out_data_r.stream_end))
      |-> (out_data_r.breath_value == '0))
    else $error("non-zero level on a closing or empty word");

endmodule

>>> design/breath_sensor_conditioner_unit.sv
// Top level of the breath sensor conditioner.
// The unit conditions raw breath converter samples. The first warmup_samples
// samples give no word; the last of them becomes the zero point, from which
// the positive and negative thresholds (zero plus/minus threshold_offset,
// clamped to 4000 and 100) and the two gains 1.4/(full scale - pos) and
// 1.4/neg are derived once. Every later sample gives exactly one word on
// out_chan: stream_start, value_valid, a signed Q1.15 breath_value saturated
// to +-32767, stream_end when the hold countdown runs out, and stuck_alarm
// when a long run of samples moderately off zero shows too narrow a spread.
// A calibrated sample is captured, evaluated, multiplied and rounded into
// the output register before the next is accepted; rounding waits while an
// earlier word is still untaken. A warm-up sample is captured and evaluated
// only. The calibration sample holds the input while one restoring divider,
// one quotient bit per cycle, works out both gains in turn. The output
// register lets the next sample be taken while a word still waits on
// out_chan. Registers sit at byte address 4*index on the APB port; the user
// must make writes only while idle, which the block does not enforce.
module breath_sensor_conditioner_unit #(
  parameter int SAMPLE_BITS    = 12,
  parameter int GAIN_FRAC_BITS = 27
) (
  input  logic                               clk,
  input  logic                               rst_n,
  bsc_stream_if.sink                         in_chan,
  bsc_stream_if.source                       out_chan,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bsc_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [bsc_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [bsc_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                               pready
);
  import bsc_pkg::*;

  bsc_cfg_t               cfg;
  bsc_cmd_t               cmd;
  bsc_stat_t              stat;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic                   in_ready;
  logic                   out_valid;
  bsc_result_t            out_data;

  // Take the sample word from the input channel.
  assign in_sample     = SAMPLE_BITS'(in_chan.data);
  assign in_chan.ready = in_ready;

  // Drive the result word from the output register.
  assign out_chan.valid = out_valid;
  assign out_chan.data  = out_data;

  bsc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer: one sample at a time, calibration divides in between.
  bsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: calibration state, hold, stuck detector, level and output word.
  bsc_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_sample (in_sample),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_chan.ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> verif/breath_sensor_conditioner_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the breath sensor conditioner unit.
module breath_sensor_conditioner_unit_test;
  import bsc_pkg::*;

  localparam int SAMPLE_W    = 12;
  localparam int FRAC_W      = 27;
  localparam int FULL        = (1 << SAMPLE_W) - 1;
  // Settle time after the last word: covers the calibration divides
  // and any warm-up sample still in flight.
  localparam int SETTLE      = 100;
  localparam int LIMIT       = 200000;
  localparam int PHASE_ITEMS = 80;
  localparam int IDLE_PCT    = 7;

  typedef enum {CAL_MID, CAL_HIGH, CAL_LOW, CAL_WIDE, CAL_TIGHT} calib_kind_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     psel, penable, pwrite, pready;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata, prdata;

  bsc_stream_if #(.data_t(logic [SAMPLE_W-1:0])) in_if ();
  bsc_stream_if #(.data_t(bsc_result_t))         out_if ();

  breath_sensor_conditioner_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the register file and of the conditioner's own state.
  bsc_cfg_t          cfg_shadow;
  logic [15:0]       warm_seen;
  logic              calibrated;
  logic [11:0]       zero_pt, pos_thr, neg_thr;
  logic [31:0]       pos_gain, neg_gain;
  logic [7:0]        hold_left;
  logic [16:0]       run_len;
  logic [11:0]       run_lo, run_hi;

  bsc_result_t       expected_words[$];
  logic [SAMPLE_W-1:0] pending_samples[$];
  int                queued_total;
  int                words_checked;
  int                errors;
  int                cycle_count;
  logic              in_fire;
  logic              steady;

  // Gain 1.4/divisor as unsigned fixed point, ties rounded up.
  function automatic logic [31:0] gain_for(int unsigned divisor);
    logic [63:0] num, den, g;
    if (divisor == 0) divisor = 1;
    num = 64'(GAIN_NUM) << FRAC_W;
    den = 64'(divisor) * 64'd5;
    g   = (num + den / 2) / den;
    if (g > 64'hFFFF_FFFF) g = 64'hFFFF_FFFF;
    return g[31:0];
  endfunction

  // Scale a magnitude into Q1.15, round half away from zero, saturate, sign.
  function automatic logic signed [15:0] scaled_level(logic [11:0] mag, logic [31:0] gain,
                                                      logic negative);
    logic [63:0] prod, q;
    prod = 64'(mag) * 64'(gain);
    q    = (prod + (64'd1 << (FRAC_W - 16))) >> (FRAC_W - 15);
    if (q > 64'(LEVEL_MAX)) q = 64'(LEVEL_MAX);
    return negative ? -$signed(q[15:0]) : $signed(q[15:0]);
  endfunction

  function automatic logic [SAMPLE_W-1:0] clip(int v);
    if (v < 0) return '0;
    if (v > FULL) return SAMPLE_W'(FULL);
    return v[SAMPLE_W-1:0];
  endfunction

  // Random sample within [lo, hi], both ends clipped to the converter range.
  function automatic logic [SAMPLE_W-1:0] span(int lo, int hi);
    int a, b;
    a = int'(clip(lo));
    b = int'(clip(hi));
    return SAMPLE_W'($urandom_range(a, b));
  endfunction

  task automatic restart_run();
    run_len = '0;
    run_lo  = SAMPLE_W'(FULL);
    run_hi  = '0;
  endtask

  task automatic report(string msg);
    errors++;
    $display("mismatch at word %0d: %s", words_checked, msg);
  endtask

  // Advance the shadow state by one accepted sample and queue the word it owes.
  task automatic condition_sample(input logic [SAMPLE_W-1:0] s);
    bsc_result_t w;
    int          eff, p, n, d, sp;
    w = '0;
    if (!calibrated) begin
      eff = (cfg_shadow.warmup_samples == 0) ? 1 : int'(cfg_shadow.warmup_samples);
      if (warm_seen != 16'hFFFF) warm_seen++;
      if (int'(warm_seen) >= eff) begin
        // The last warm-up sample fixes zero, thresholds and gains for good.
        calibrated = 1'b1;
        zero_pt    = s;
        p = int'(s) + int'(cfg_shadow.threshold_offset);
        if (p > CLAMP_POS) p = CLAMP_POS;
        n = int'(s) - int'(cfg_shadow.threshold_offset);
        if (n < CLAMP_NEG) n = CLAMP_NEG;
        pos_thr  = 12'(p);
        neg_thr  = 12'(n);
        pos_gain = gain_for(FULL > p ? FULL - p : 1);
        neg_gain = gain_for(n);
      end
    end else begin
      d = (s > zero_pt) ? int'(s) - int'(zero_pt) : int'(zero_pt) - int'(s);
      if (d > int'(cfg_shadow.stuck_low_dev) && d < int'(cfg_shadow.stuck_high_dev)) begin
        if (s < run_lo) run_lo = s;
        if (s > run_hi) run_hi = s;
        run_len++;
        if (int'(run_len) > int'(cfg_shadow.stuck_window)) begin
          sp = (run_hi >= run_lo) ? int'(run_hi) - int'(run_lo) : 0;
          if (sp < int'(cfg_shadow.stuck_spread)) w.stuck_alarm = 1'b1;
          restart_run();
        end
      end else begin
        restart_run();
      end

      // Reload the hold on any over-threshold sample; zero hold acts as one.
      if (s > pos_thr || s < neg_thr) begin
        if (hold_left == 0) w.stream_start = 1'b1;
        hold_left = (cfg_shadow.hold_samples == 0) ? 8'd1 : cfg_shadow.hold_samples;
      end

      if (hold_left != 0) begin
        hold_left--;
        w.value_valid = 1'b1;
        if (hold_left != 0) begin
          if (s > pos_thr) w.breath_value = scaled_level(s - pos_thr, pos_gain, 1'b0);
          // Negative side wins where both thresholds are crossed.
          if (s < neg_thr) w.breath_value = scaled_level(neg_thr - s, neg_gain, 1'b1);
        end else begin
          w.stream_end = 1'b1;
        end
      end
      expected_words.push_back(w);
    end
  endtask

  task automatic check_word(input bsc_result_t got);
    bsc_result_t want;
    if (expected_words.size() == 0) begin
      report($sformatf("word with nothing expected: %h", got));
    end else begin
      want = expected_words.pop_front();
      if (got.stream_start !== want.stream_start)
        report($sformatf("stream_start got %b want %b", got.stream_start, want.stream_start));
      if (got.value_valid !== want.value_valid)
        report($sformatf("value_valid got %b want %b", got.value_valid, want.value_valid));
      if (got.breath_value !== want.breath_value)
        report($sformatf("breath_value got %0d want %0d", got.breath_value, want.breath_value));
      if (got.stream_end !== want.stream_end)
        report($sformatf("stream_end got %b want %b", got.stream_end, want.stream_end));
      if (got.stuck_alarm !== want.stuck_alarm)
        report($sformatf("stuck_alarm got %b want %b", got.stuck_alarm, want.stuck_alarm));
    end
    words_checked++;
  endtask

  // Monitor: check the outgoing word first, since it can never belong to a
  // sample taken at the same edge, then predict for the incoming one.
  always @(posedge clk) begin
    in_fire <= in_if.valid && in_if.ready;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) check_word(out_if.data);
      if (in_if.valid && in_if.ready) condition_sample(in_if.data);
    end
  end

  // Driver: hold the offered sample until taken, then offer the next or idle.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fire) begin
      if (pending_samples.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_if.valid <= 1'b1;
        in_if.data  <= pending_samples.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    out_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_WARMUP:       cfg_shadow.warmup_samples   = value[15:0];
      REG_THR_OFFSET:   cfg_shadow.threshold_offset = value[11:0];
      REG_HOLD:         cfg_shadow.hold_samples     = value[7:0];
      REG_STUCK_WINDOW: cfg_shadow.stuck_window     = value[15:0];
      REG_STUCK_SPREAD: cfg_shadow.stuck_spread     = value[11:0];
      REG_STUCK_LOW:    cfg_shadow.stuck_low_dev    = value[11:0];
      REG_STUCK_HIGH:   cfg_shadow.stuck_high_dev   = value[11:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_run_regs(int hold, int win, int spr, int lo, int hi);
    write_reg(REG_HOLD, hold);
    write_reg(REG_STUCK_WINDOW, win);
    write_reg(REG_STUCK_SPREAD, spr);
    write_reg(REG_STUCK_LOW, lo);
    write_reg(REG_STUCK_HIGH, hi);
  endtask

  task automatic add_sample(input logic [SAMPLE_W-1:0] s);
    pending_samples.push_back(s);
    queued_total++;
  endtask

  // Wait until every sample is taken and every word is in, then let the
  // block settle so that no silent sample is still being worked on.
  task automatic drain();
    while (pending_samples.size() != 0 || in_if.valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // A breath: a burst past one threshold, then a quiet tail that may or may
  // not outlast the hold.
  task automatic queue_breath();
    int k, m, up;
    k  = $urandom_range(1, 8);
    up = $urandom_range(0, 1);
    m  = $urandom_range(0, (cfg_shadow.hold_samples + 3 > 12) ? 12
                            : cfg_shadow.hold_samples + 3);
    repeat (k) add_sample(up ? span(pos_thr + 1, FULL) : span(0, int'(neg_thr) - 1));
    repeat (m) add_sample(span(neg_thr, pos_thr));
  endtask

  // A run moderately off zero with a narrow spread, long enough to trip the
  // stuck check where the window allows it.
  task automatic queue_stuck_run();
    int len, dev, base, jit;
    len = int'(cfg_shadow.stuck_window) + $urandom_range(1, 3);
    if (len > 40) len = $urandom_range(5, 40);
    if (int'(cfg_shadow.stuck_low_dev) + 1 <= int'(cfg_shadow.stuck_high_dev) - 1)
      dev = $urandom_range(cfg_shadow.stuck_low_dev + 1, cfg_shadow.stuck_high_dev - 1);
    else
      dev = $urandom_range(0, FULL);
    base = $urandom_range(0, 1) ? int'(zero_pt) + dev : int'(zero_pt) - dev;
    jit  = $urandom_range(0, (cfg_shadow.stuck_spread + 4 > 64) ? 64
                              : cfg_shadow.stuck_spread + 4);
    repeat (len) add_sample(clip(base + $urandom_range(0, jit)));
  endtask

  initial begin
    calib_kind_t kind;
    int          z, off, target;

    // Known values on every input from time zero.
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_fire      = 1'b0;
    steady       = 1'b0;
    errors       = 0;
    queued_total = 0;
    words_checked = 0;

    cfg_shadow = '{WARMUP_RESET, THR_OFFSET_RESET, HOLD_RESET, STUCK_WIN_RESET,
                   STUCK_SPR_RESET, STUCK_LOW_RESET, STUCK_HIGH_RESET};
    warm_seen  = '0;
    calibrated = 1'b0;
    zero_pt    = 12'(ZERO_RESET);
    pos_thr    = 12'(POS_RESET);
    neg_thr    = 12'(NEG_RESET);
    pos_gain   = '0;
    neg_gain   = '0;
    hold_left  = '0;
    restart_run();

    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Warm-up at the longest setting: these samples must stay silent.
    write_reg(REG_WARMUP, 32'h0000_FFFF);
    write_reg(REG_THR_OFFSET, 32'h0000_0FFF);
    repeat (6) add_sample(SAMPLE_W'($urandom_range(0, FULL)));
    drain();

    // Pick where the zero point lands: mid scale, hard against either rail
    // (thresholds clamped, possibly overlapping), or the widest and tightest
    // offsets.
    write_reg(REG_THR_OFFSET, 0);
    kind = calib_kind_t'($urandom_range(0, 4));
    case (kind)
      CAL_MID:   begin z = $urandom_range(1500, 2600); off = $urandom_range(30, 300); end
      CAL_HIGH:  begin z = $urandom_range(3980, FULL); off = $urandom_range(0, 40);   end
      CAL_LOW:   begin z = $urandom_range(0, 200);     off = $urandom_range(0, 150);  end
      CAL_WIDE:  begin z = $urandom_range(0, FULL);    off = FULL;                     end
      default:   begin z = $urandom_range(0, FULL);    off = 0;                        end
    endcase
    write_reg(REG_THR_OFFSET, off);

    // Lower the warm-up below the count already reached (zero acts as one),
    // or just a little above it so that it runs out naturally.
    if ($urandom_range(0, 1)) begin
      write_reg(REG_WARMUP, 0);
      add_sample(SAMPLE_W'(z));
    end else begin
      write_reg(REG_WARMUP, 10);
      repeat (3) add_sample(SAMPLE_W'($urandom_range(0, FULL)));
      add_sample(SAMPLE_W'(z));
    end
    drain();

    // Directed: rails, zero, each threshold and its neighbour, a short stuck
    // run, and a quiet tail that lets a short hold expire.
    set_run_regs(3, 3, 50, 20, 800);
    add_sample('0);
    add_sample(SAMPLE_W'(FULL));
    add_sample(zero_pt);
    add_sample(pos_thr);
    add_sample(clip(int'(pos_thr) + 1));
    add_sample(neg_thr);
    add_sample(clip(int'(neg_thr) - 1));
    repeat (5) add_sample(clip(int'(zero_pt) + 30));
    repeat (4) add_sample(zero_pt);
    drain();

    // Random phases: register extremes first, then assorted settings. One
    // phase runs with no idling on either side.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_run_regs(0, 1, FULL, 0, FULL);
        1: set_run_regs(255, 16'hFFFF, 0, FULL, 0);
        default: begin
          set_run_regs($urandom_range(1, 12), $urandom_range(2, 40), $urandom_range(0, 60),
                       $urandom_range(0, 40), $urandom_range(100, 900));
          // Calibration is spent: these must change nothing now.
          write_reg(REG_WARMUP, $urandom);
          write_reg(REG_THR_OFFSET, $urandom);
        end
      endcase
      steady = (ph == 3);
      target = queued_total + PHASE_ITEMS;
      while (queued_total < target) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: queue_breath();
          5, 6, 7:       queue_stuck_run();
          default:       repeat ($urandom_range(1, 4))
                           add_sample(SAMPLE_W'($urandom_range(0, FULL)));
        endcase
      end
      drain();
    end

    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

endmodule

>>> sim.f
design/bsc_pkg.sv
design/bsc_stream_if.sv
design/bsc_regs.sv
design/bsc_div.sv
design/bsc_ctrl.sv
design/bsc_dp.sv
design/breath_sensor_conditioner_unit.sv
verif/breath_sensor_conditioner_unit_test.sv
